// File: src/assert_macros.svh
// assertion helpers included by running_median
// each macro samples on clk and is disabled while rst is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked at every rising clock edge
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/rmed_pkg.sv
// shared types and constants for the running median block
// no dependencies
package rmed_pkg;

  localparam int SAMPLE_W = 32;
  localparam int MEDIAN_W = 33;
  localparam int COUNT_W  = 8;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       start_req;
  } in_t;

  typedef struct packed {
    logic signed [MEDIAN_W-1:0] median_twice;
    logic [COUNT_W-1:0]         kept_count;
    logic                       overflow;
  } out_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INSERT,
    OP_POPINS
  } chain_op_t;

  // command broadcast to every cell of one chain
  typedef struct packed {
    chain_op_t                  op;
    logic signed [SAMPLE_W-1:0] x;
    logic                       clr;
  } chain_ctl_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       valid;
    logic                       b;
  } link_t;

  localparam link_t FRONT_LINK = '{value: '0, valid: 1'b1, b: 1'b0};
  localparam link_t END_LINK   = '{value: '0, valid: 1'b0, b: 1'b1};

endpackage

// File: src/rmed_cell.sv
// one cell of a sorted chain: holds a value and a valid bit
// depends on rmed_pkg
module rmed_cell (
  input  logic               clk,
  input  logic               rst,
  input  rmed_pkg::chain_ctl_t ctl,
  input  logic               desc,
  input  rmed_pkg::link_t    inner,
  input  rmed_pkg::link_t    outer,
  output rmed_pkg::link_t    link
);
  import rmed_pkg::*;

  logic signed [SAMPLE_W-1:0] value;
  logic signed [SAMPLE_W-1:0] value_next;
  logic                       valid;
  logic                       valid_next;
  logic                       veff;
  logic                       ahead;

  always_comb begin
    veff   = valid & ~ctl.clr;
    ahead  = desc ? (ctl.x > value) : (ctl.x < value);
    link.value = value;
    link.valid = veff;
    // new value belongs at or ahead of this cell
    link.b     = ~veff | ahead;
  end

  always_comb begin
    case (ctl.op)
      OP_INSERT: begin
        value_next = link.b ? (inner.b ? inner.value : ctl.x) : value;
        valid_next = veff | inner.valid;
      end
      OP_POPINS: begin
        // front leaves, everything moves inward, x lands in the gap
        value_next = outer.b ? (link.b ? value : ctl.x) : outer.value;
        valid_next = veff;
      end
      default: begin
        value_next = value;
        valid_next = veff;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

endmodule

// File: src/rmed_chain.sv
// row of cells kept sorted, front cell nearest the median
// depends on rmed_pkg and rmed_cell
module rmed_chain #(
  parameter int DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rmed_pkg::chain_ctl_t          ctl,
  input  logic                          desc,
  output logic signed [rmed_pkg::SAMPLE_W-1:0] front
);
  import rmed_pkg::*;

  link_t lk [DEPTH];

  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    link_t inner;
    link_t outer;
    if (gi == 0) begin : g_first
      assign inner = FRONT_LINK;
    end else begin : g_mid
      assign inner = lk[gi-1];
    end
    if (gi == DEPTH - 1) begin : g_last
      assign outer = END_LINK;
    end else begin : g_rest
      assign outer = lk[gi+1];
    end
    rmed_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctl   (ctl),
      .desc  (desc),
      .inner (inner),
      .outer (outer),
      .link  (lk[gi])
    );
  end

  assign front = lk[0].value;

endmodule

// File: src/running_median.sv
// running median: two sorted cell chains, lower half and upper half
// result path: an accepted item is held in pend, then registered into rsp and rsp_valid once the output is free
// throughput: one item per cycle while req_stall is low; it rises when a pending item meets a stalled output
// reset: clears the count and every cell valid bit at once, no clearing pass
// a start request empties both chains in the same cycle as its sample is taken
module running_median #(
  parameter int CAPACITY = 128
) (
  input  logic          clk,
  input  logic          rst,
  input  rmed_pkg::in_t req,
  input  logic          req_valid,
  output logic          req_stall,
  output rmed_pkg::out_t rsp,
  output logic          rsp_valid,
  input  logic          rsp_stall
);
  import rmed_pkg::*;

  `include "assert_macros.svh"

  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int LDEPTH = (CAPACITY + 1) / 2;
  localparam int UDEPTH = CAPACITY / 2;

  logic [CW-1:0]              n;
  logic [CW-1:0]              n_eff;
  logic [CW-1:0]              n_next;
  logic                       full;
  logic                       accept;
  logic                       move;
  logic                       pend;
  logic                       pend_drop;
  logic [CW-1:0]              pend_cnt;
  logic signed [SAMPLE_W-1:0] lf;
  logic signed [SAMPLE_W-1:0] uf;
  logic signed [MEDIAN_W-1:0] lf_x;
  logic signed [MEDIAN_W-1:0] uf_x;
  logic signed [MEDIAN_W-1:0] median;
  logic [CW+COUNT_W-1:0]      cnt_x;
  chain_ctl_t                 lctl;
  chain_ctl_t                 uctl;

  assign req_stall = pend & rsp_valid & rsp_stall;
  assign accept    = req_valid & ~req_stall;
  assign move      = pend & (~rsp_valid | ~rsp_stall);

  always_comb begin
    n_eff  = req.start_req ? '0 : n;
    full   = (n_eff == CW'(CAPACITY));
    n_next = full ? n_eff : CW'(n_eff + 1'b1);
    lctl   = '{op: OP_NONE, x: req.sample, clr: accept & req.start_req};
    uctl   = '{op: OP_NONE, x: req.sample, clr: accept & req.start_req};
    if (accept && !full) begin
      if (!n_eff[0]) begin
        // lower half grows
        if (n_eff == '0 || req.sample <= uf) begin
          lctl.op = OP_INSERT;
        end else begin
          lctl.op = OP_INSERT;
          lctl.x  = uf;
          uctl.op = OP_POPINS;
        end
      end else begin
        // upper half grows
        if (req.sample >= lf) begin
          uctl.op = OP_INSERT;
        end else begin
          uctl.op = OP_INSERT;
          uctl.x  = lf;
          lctl.op = OP_POPINS;
        end
      end
    end
  end

  rmed_chain #(.DEPTH(LDEPTH)) u_lower (
    .clk   (clk),
    .rst   (rst),
    .ctl   (lctl),
    .desc  (1'b1),
    .front (lf)
  );

  rmed_chain #(.DEPTH(UDEPTH)) u_upper (
    .clk   (clk),
    .rst   (rst),
    .ctl   (uctl),
    .desc  (1'b0),
    .front (uf)
  );

  always_comb begin
    lf_x   = MEDIAN_W'(lf);
    uf_x   = MEDIAN_W'(uf);
    median = pend_cnt[0] ? (lf_x + lf_x) : (lf_x + uf_x);
    cnt_x  = {{COUNT_W{1'b0}}, pend_cnt};
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_drop <= full;
      pend_cnt  <= n_next;
    end
    if (move) begin
      rsp.median_twice <= median;
      rsp.kept_count   <= cnt_x[COUNT_W-1:0];
      rsp.overflow     <= pend_drop;
    end
    if (rst) begin
      n         <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        n <= n_next;
      end
      pend <= accept | (pend & ~move);
      if (move) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  `ASSERT_ALWAYS(a_count_bound, n <= CW'(CAPACITY), "count above capacity")
  `ASSERT_IMPLY(a_drop_full, pend && pend_drop, pend_cnt == CW'(CAPACITY), "drop below capacity")
  `ASSERT_NEXT(a_count_step, accept && !full, n == CW'($past(n_eff) + 1'b1), "count did not advance")
  `ASSERT_IMPLY(a_halves_order, pend && pend_cnt >= CW'(2), lf <= uf, "lower front above upper front")

endmodule

// File: test/median_check_pkg.sv
`timescale 1ns / 100ps
// scoreboard for the running median testbench: sorted-store predictor and result check
// depends on rmed_pkg for the item types
package median_check_pkg;

  import rmed_pkg::*;

  class median_scoreboard;
    int capacity;
    logic signed [SAMPLE_W-1:0] sorted_q[$];
    out_t expected_q[$];
    int mismatches;

    function new(int capacity);
      this.capacity = capacity;
      mismatches = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // insert into the sorted store and work out twice the median
    function void note_sample(in_t it);
      out_t r;
      int pos;
      int mid;
      logic signed [SAMPLE_W-1:0] v;
      logic signed [MEDIAN_W-1:0] lo;
      logic signed [MEDIAN_W-1:0] hi;
      v = it.sample;
      if (it.start_req) sorted_q.delete();
      r.overflow = 1'b0;
      if (sorted_q.size() < capacity) begin
        pos = 0;
        // equal values go after the ones already stored
        while (pos < sorted_q.size() && sorted_q[pos] <= v) pos++;
        sorted_q.insert(pos, v);
      end else begin
        r.overflow = 1'b1;
      end
      mid = sorted_q.size() / 2;
      hi = sorted_q[mid];
      if (sorted_q.size() % 2 == 1) lo = hi;
      else lo = sorted_q[mid-1];
      r.median_twice = lo + hi;
      r.kept_count = COUNT_W'(sorted_q.size());
      expected_q.push_back(r);
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: median_twice=%0d kept_count=%0d overflow=%0b",
                   got.median_twice, got.kept_count, got.overflow);
        return;
      end
      want = expected_q.pop_front();
      if (got.median_twice !== want.median_twice || got.kept_count !== want.kept_count ||
          got.overflow !== want.overflow) begin
        mismatches++;
        if (mismatches <= 10)
          $display("median mismatch: expected %0d/%0d/%0b got %0d/%0d/%0b",
                   want.median_twice, want.kept_count, want.overflow,
                   got.median_twice, got.kept_count, got.overflow);
      end
    endfunction
  endclass

endpackage

// File: test/tb_top.sv
`timescale 1ns / 100ps
// top of the running median testbench: clock, reset, stimulus phases and monitor
// depends on rmed_pkg, median_check_pkg and the running_median block
module tb_top;

  import rmed_pkg::*;
  import median_check_pkg::*;

  localparam int CAPACITY    = 128;
  localparam int PHASE_ITEMS = 350;
  localparam int CYCLE_LIMIT = 400000;

  typedef enum int {
    MIX_ANY,
    MIX_NEAR_ZERO,
    MIX_EXTREME
  } value_mix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  in_t req = '0;
  logic req_valid = 1'b0;
  logic req_stall;
  out_t rsp;
  logic rsp_valid;
  logic rsp_stall = 1'b0;

  int req_idle_pct = 0;
  int rsp_stall_pct = 0;
  int cycle_count = 0;
  int sent_count;

  median_scoreboard sb = new(CAPACITY);

  running_median #(.CAPACITY(CAPACITY)) dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .rsp(rsp),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(posedge clk) begin
    rsp_stall <= (rsp_stall_pct != 0) && ($urandom_range(99) < rsp_stall_pct);
  end

  // inputs noted before results so a same-edge pair stays in order
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) sb.note_sample(req);
      if (rsp_valid && !rsp_stall) sb.check_result(rsp);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[running_median] ERROR");
      $finish;
    end
  end

  // valid stays high between back-to-back items
  task automatic send_item(input logic signed [SAMPLE_W-1:0] v, input logic start);
    if (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < req_idle_pct) @(posedge clk);
    end
    req <= '{sample: v, start_req: start};
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sent_count++;
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(value_mix_t mix);
    case (mix)
      MIX_NEAR_ZERO: return int'($urandom_range(16)) - 8;
      MIX_EXTREME: begin
        case ($urandom_range(4))
          0: return 32'sh7fffffff;
          1: return 32'sh80000000;
          2: return 32'sh00000000;
          3: return -32'sd1;
          default: return $urandom;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic run_sequences(input int budget);
    int len;
    value_mix_t mix;
    logic start;
    sent_count = 0;
    while (sent_count < budget) begin
      // mostly short sequences, now and then a long one near or past the store capacity
      if ($urandom_range(99) < 15) len = $urandom_range(150, 120);
      else len = $urandom_range(24, 1);
      mix = value_mix_t'($urandom_range(2));
      // sometimes continue the previous sequence without a start
      start = ($urandom_range(99) < 88);
      for (int i = 0; i < len && sent_count < budget; i++) begin
        if (i == 0) send_item(pick_sample(mix), start);
        else if ($urandom_range(99) < 3) send_item($urandom, 1'b1);
        else send_item(pick_sample(mix), 1'b0);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, wide sums, equal values, restarts
    send_item(32'sh80000000, 1'b1);
    send_item(32'sh7fffffff, 1'b0);
    send_item(32'sh00000000, 1'b0);
    send_item(-32'sd1, 1'b0);
    send_item(32'sd5, 1'b0);
    send_item(32'sd5, 1'b0);
    send_item(32'sd5, 1'b0);
    send_item(32'sh7fffffff, 1'b1);
    send_item(32'sh7fffffff, 1'b0);
    send_item(32'sh80000000, 1'b1);
    send_item(32'sh80000000, 1'b0);
    send_item(32'sh55555555, 1'b1);
    send_item(32'shaaaaaaaa, 1'b0);
    send_item(32'sd9, 1'b1);
    send_item(32'sd7, 1'b0);
    send_item(32'sd3, 1'b0);
    send_item(32'sd1, 1'b0);
    send_item(-32'sd4, 1'b0);
    send_item(32'sd0, 1'b1);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
        1: begin req_idle_pct = 59; rsp_stall_pct = 0;  end
        2: begin req_idle_pct = 0;  rsp_stall_pct = 59; end
        default: begin req_idle_pct = 25; rsp_stall_pct = 25; end
      endcase
      run_sequences(PHASE_ITEMS);
      drain();
    end

    rsp_stall_pct = 0;
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[running_median] OK");
    end else begin
      $display("[running_median] ERROR");
    end
    $finish;
  end

endmodule
